// ===== sv/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg - shared types and constants for the sample playback mixer
// Payload structs of the input and result channels, command codes and the
// fixed field widths.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int MIX_W     = 20;
    localparam int BASE_NOTE = 48;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [1:0] CMD_LOAD     = 2'd2;
    localparam logic [1:0] CMD_SET_LEN  = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [6:0]         note;
        logic [13:0]        frame_index;
        logic signed [15:0] left_value;
        logic signed [15:0] right_value;
        logic [14:0]        length;
    } spm_in_t;

    typedef struct packed {
        logic signed [MIX_W-1:0] left_mix;
        logic signed [MIX_W-1:0] right_mix;
    } spm_out_t;

endpackage

// ===== sv/sample_playback_mixer.sv =====
// ----------------------------------------------------------------------------
// sample_playback_mixer - polyphonic sample player and stereo mixer
// Per-note sample store, lengths and play positions; a tick walks all voices
// through one shared read/compare/accumulate path and returns one mix.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one command transaction: tick, note on,
//   load sample frame or set note length. Only a tick produces a result,
//   on m_valid/m_ready/m_data. cfg_valid/cfg_ready/cfg_data write the
//   output channel count (1: right mix forced to zero); write it while idle.
//   Note on, load and set length are written at the accepting edge and
//   s_ready stays high.
//   A tick walks the voices: one voice enters the length/position read per
//   cycle, followed by the sample memory read and the accumulate stage;
//   s_ready is low meanwhile and returns with the result, so the next
//   transaction is taken only after the result is registered.
//   A finished result waits in the output register; load and note commands
//   are still taken while it waits. A following tick holds its result, and
//   keeps s_ready low, until the previous one is taken.
//   Reset clears all voices, lengths and the output; the channel count
//   returns to 2. Sample memory is not cleared: read only written frames.
module sample_playback_mixer
    import spm_pkg::*;
#(
    parameter int NUM_VOICES  = 24,
    parameter int MAX_FRAMES  = 16384,
    parameter int SAMPLE_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  spm_in_t    s_data,

    output logic       m_valid,
    input  logic       m_ready,
    output spm_out_t   m_data,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    localparam int VIW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CW    = $clog2(NUM_VOICES + 1);
    localparam int PW    = $clog2(MAX_FRAMES + 1);
    localparam int DEPTH = NUM_VOICES * MAX_FRAMES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = SAMPLE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // storage
    logic [2*SW-1:0] smp_mem [DEPTH];
    logic [PW-1:0]   len_mem [NUM_VOICES];
    logic [PW-1:0]   pos_mem [NUM_VOICES];

    logic [1:0]              state_reg, state_next;
    logic [1:0]              chans_reg;
    logic [NUM_VOICES-1:0]   active_reg, active_next;
    logic [NUM_VOICES-1:0]   len_ok_reg, len_ok_next;
    logic [CW-1:0]           rd_cnt_reg;
    logic [AW-1:0]           base0_reg;
    logic                    v1_reg;
    logic [VIW-1:0]          idx1_reg;
    logic [AW-1:0]           base1_reg;
    logic [PW-1:0]           len_q_reg;
    logic [PW-1:0]           pos_q_reg;
    logic                    v2_reg;
    logic [2*SW-1:0]         smp_q_reg;
    logic signed [MIX_W-1:0] accl_reg, accr_reg;
    logic                    m_valid_reg;
    spm_out_t                m_data_reg;

    // input decode
    logic           s_acc;
    logic [7:0]     note_diff;
    logic           in_range;
    logic [VIW-1:0] in_voice;
    logic           do_note, do_load, do_len, tick_start;
    logic [AW-1:0]  load_addr;
    logic [PW-1:0]  len_sat;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_valid && s_ready;

    assign note_diff = {1'b0, s_data.note} - 8'(BASE_NOTE);
    assign in_range  = ({1'b0, s_data.note} >= 8'(BASE_NOTE))
                       && (32'(note_diff) < NUM_VOICES);
    assign in_voice  = note_diff[VIW-1:0];

    assign tick_start = s_acc && (s_data.cmd == CMD_TICK);
    assign do_note    = s_acc && in_range && (s_data.cmd == CMD_NOTE_ON);
    assign do_load    = s_acc && in_range && (s_data.cmd == CMD_LOAD)
                        && (32'(s_data.frame_index) < MAX_FRAMES);
    assign do_len     = s_acc && in_range && (s_data.cmd == CMD_SET_LEN);

    assign load_addr  = AW'(in_voice) * AW'(MAX_FRAMES) + AW'(s_data.frame_index);
    assign len_sat    = (32'(s_data.length) > MAX_FRAMES) ? PW'(MAX_FRAMES)
                                                           : PW'(s_data.length);

    // voice walk
    logic           issue;
    logic [VIW-1:0] rd_idx;
    logic           act1, expire, play;
    logic [PW-1:0]  eff_len;
    logic [AW-1:0]  smp_addr;
    logic           walk_done;

    assign issue    = (state_reg == ST_TICK) && (rd_cnt_reg != CW'(NUM_VOICES));
    assign rd_idx   = rd_cnt_reg[VIW-1:0];
    assign act1     = v1_reg && active_reg[idx1_reg];
    assign eff_len  = len_ok_reg[idx1_reg] ? len_q_reg : '0;
    assign expire   = act1 && (pos_q_reg >= eff_len);
    assign play     = act1 && !expire;
    assign smp_addr = base1_reg + AW'(pos_q_reg);
    assign walk_done = (state_reg == ST_TICK) && (rd_cnt_reg == CW'(NUM_VOICES))
                       && !v1_reg && !v2_reg;

    // position write port: note on rewinds, a playing voice advances
    logic           pos_we;
    logic [VIW-1:0] pos_wa;
    logic [PW-1:0]  pos_wd;

    assign pos_we = do_note || play;
    assign pos_wa = do_note ? in_voice : idx1_reg;
    assign pos_wd = do_note ? '0 : (pos_q_reg + PW'(1));

    always_comb begin
        active_next = active_reg;
        len_ok_next = len_ok_reg;
        if (do_note) begin
            active_next[in_voice] = 1'b1;
        end
        if (expire) begin
            active_next[idx1_reg] = 1'b0;
        end
        if (do_len) begin
            len_ok_next[in_voice] = 1'b1;
        end
    end

    // halve with floor and widen to the mix width
    logic signed [SW-1:0] smp_l, smp_r, half_l, half_r;

    assign smp_l  = smp_q_reg[2*SW-1:SW];
    assign smp_r  = smp_q_reg[SW-1:0];
    assign half_l = smp_l >>> 1;
    assign half_r = smp_r >>> 1;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (tick_start) begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                if (walk_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (do_load) begin
            smp_mem[load_addr] <= {SW'($unsigned(s_data.left_value)),
                                   SW'($unsigned(s_data.right_value))};
        end
        if (play) begin
            smp_q_reg <= smp_mem[smp_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_len) begin
            len_mem[in_voice] <= len_sat;
        end
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
        if (issue) begin
            len_q_reg <= len_mem[rd_idx];
            pos_q_reg <= pos_mem[rd_idx];
        end
    end

    // payload pipeline
    always_ff @(posedge aclk) begin
        if (issue) begin
            idx1_reg  <= rd_idx;
            base1_reg <= base0_reg;
        end
        if (tick_start) begin
            base0_reg <= '0;
            accl_reg  <= '0;
            accr_reg  <= '0;
        end else begin
            if (issue) begin
                base0_reg <= base0_reg + AW'(MAX_FRAMES);
            end
            if (v2_reg) begin
                accl_reg <= accl_reg + MIX_W'(half_l);
                accr_reg <= accr_reg + MIX_W'(half_r);
            end
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg.left_mix  <= (chans_reg >= 2'd1) ? accl_reg : '0;
            m_data_reg.right_mix <= (chans_reg >= 2'd2) ? accr_reg : '0;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chans_reg   <= 2'd2;
            active_reg  <= '0;
            len_ok_reg  <= '0;
            rd_cnt_reg  <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
            len_ok_reg <= len_ok_next;
            if (cfg_valid && cfg_ready) begin
                chans_reg <= cfg_data;
            end
            if (tick_start) begin
                rd_cnt_reg <= '0;
            end else if (issue) begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            v1_reg <= issue;
            v2_reg <= play;
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking regression for sample_playback_mixer
// Drives command transactions with random gaps and output back-pressure. A
// scoreboard keeps its own copy of the voices, lengths, positions and written
// frames, predicts every tick's stereo mix and checks it against the output.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    localparam int VOICES        = 24;
    localparam int FRAMES        = 16384;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;

    class mix_scoreboard;
        logic [14:0] note_len [VOICES];
        logic [14:0] play_pos [VOICES];
        bit          active   [VOICES];
        bit [31:0]   frames   [int];
        logic [1:0]  channels;
        spm_out_t    expected_mix [$];
        int          mismatches;
        int          mixes_checked;

        function new();
            foreach (note_len[v]) begin
                note_len[v] = '0;
                play_pos[v] = '0;
                active[v]   = 1'b0;
            end
            channels      = 2'd2;
            mismatches    = 0;
            mixes_checked = 0;
        endfunction

        function bit voice_of(logic [6:0] note, output int v);
            v = int'(note) - BASE_NOTE;
            return (v >= 0 && v < VOICES);
        endfunction

        function bit frame_written(int v, int pos);
            return frames.exists(v * FRAMES + pos);
        endfunction

        function void apply_command(spm_in_t t);
            int        v;
            int        lsum;
            int        rsum;
            int        lv;
            int        rv;
            bit [31:0] f;
            spm_out_t  mix;
            if (t.cmd == CMD_TICK) begin
                lsum = 0;
                rsum = 0;
                for (v = 0; v < VOICES; v++) begin
                    if (!active[v])
                        continue;
                    if (play_pos[v] >= note_len[v]) begin
                        active[v] = 1'b0;
                        continue;
                    end
                    f = frame_written(v, play_pos[v]) ?
                        frames[v * FRAMES + play_pos[v]] : '0;
                    lv = $signed(f[31:16]);
                    rv = $signed(f[15:0]);
                    // halving rounds toward minus infinity
                    lsum += lv >>> 1;
                    rsum += rv >>> 1;
                    play_pos[v] = play_pos[v] + 15'd1;
                end
                if (channels < 2'd1)
                    lsum = 0;
                if (channels < 2'd2)
                    rsum = 0;
                mix.left_mix  = lsum[MIX_W-1:0];
                mix.right_mix = rsum[MIX_W-1:0];
                expected_mix = {expected_mix, mix};
                return;
            end
            if (!voice_of(t.note, v))
                return;
            case (t.cmd)
                CMD_NOTE_ON: begin
                    play_pos[v] = '0;
                    active[v]   = 1'b1;
                end
                CMD_LOAD: begin
                    frames[v * FRAMES + int'(t.frame_index)] = {t.left_value, t.right_value};
                end
                default: begin
                    note_len[v] = (t.length > FRAMES) ? 15'(FRAMES) : t.length;
                end
            endcase
        endfunction

        function void check_mix(spm_out_t got);
            spm_out_t want;
            mixes_checked++;
            if (expected_mix.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: mix with none expected: left %0d right %0d",
                             got.left_mix, got.right_mix);
                return;
            end
            want = expected_mix.pop_front();
            if (got.left_mix !== want.left_mix || got.right_mix !== want.right_mix) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: mix %0d: expected left %0d right %0d, %s %0d right %0d",
                             mixes_checked, want.left_mix, want.right_mix, "got left",
                             got.left_mix, got.right_mix);
            end
        endfunction

        function int pending();
            return expected_mix.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    spm_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    spm_out_t   m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;

    mix_scoreboard sb = new();

    int tx_gap     = 0;
    bit tx_burst   = 1'b0;
    bit rx_burst   = 1'b0;
    int rx_stall   = 0;
    int sent_cnt   = 0;
    int tick_cnt   = 0;
    int note_cnt   = 0;
    int load_cnt   = 0;
    int length_cnt = 0;
    int cfg_cnt    = 0;

    sample_playback_mixer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random hold-off per transaction, or a long stall on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            if (rx_stall > 0) begin
                gap      = rx_stall;
                rx_stall = 0;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_mix(m_data);
    end

    task automatic send_item(spm_in_t t);
        if (tx_gap > 0)
            repeat (tx_gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        sb.apply_command(t);
        sent_cnt++;
        case (t.cmd)
            CMD_TICK:    tick_cnt++;
            CMD_NOTE_ON: note_cnt++;
            CMD_LOAD:    load_cnt++;
            default:     length_cnt++;
        endcase
        // drop valid only when the next transaction is not back to back
        tx_gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (tx_gap > 0)
            s_valid <= 1'b0;
    endtask

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 19))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Load any frame the tick is about to read that was never written
    task automatic send_tick(spm_in_t t);
        spm_in_t fill;
        int      v;
        for (v = 0; v < VOICES; v++) begin
            if (sb.active[v] && sb.play_pos[v] < sb.note_len[v] &&
                !sb.frame_written(v, sb.play_pos[v])) begin
                fill.cmd         = CMD_LOAD;
                fill.note        = 7'(BASE_NOTE + v);
                fill.frame_index = 14'(sb.play_pos[v]);
                fill.left_value  = draw_sample();
                fill.right_value = draw_sample();
                fill.length      = 15'($urandom());
                send_item(fill);
            end
        end
        t.cmd = CMD_TICK;
        send_item(t);
    endtask

    task automatic send_cmd(logic [1:0] cmd, int note, int frame, logic [15:0] lval,
                            logic [15:0] rval, int len);
        spm_in_t t;
        t.cmd         = cmd;
        t.note        = 7'(note);
        t.frame_index = 14'(frame);
        t.left_value  = lval;
        t.right_value = rval;
        t.length      = 15'(len);
        if (cmd == CMD_TICK)
            send_tick(t);
        else
            send_item(t);
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_channels(logic [1:0] count);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.channels = count;
        cfg_cnt++;
    endtask

    task automatic random_item();
        spm_in_t t;
        int      v;
        int      pick;
        int      top;
        pick          = $urandom_range(0, 99);
        v             = $urandom_range(0, VOICES - 1);
        t.cmd         = CMD_TICK;
        t.note        = 7'(BASE_NOTE + v);
        t.frame_index = 14'($urandom());
        t.left_value  = draw_sample();
        t.right_value = draw_sample();
        t.length      = 15'($urandom());
        if (pick >= 35 && $urandom_range(0, 9) == 0)
            t.note = 7'($urandom());
        if (pick < 35) begin
            send_tick(t);
        end else if (pick < 50) begin
            t.cmd = CMD_NOTE_ON;
            send_item(t);
        end else if (pick < 85) begin
            t.cmd = CMD_LOAD;
            if ($urandom_range(0, 9) < 7) begin
                top = int'(sb.note_len[v]) + 2;
                if (top > FRAMES - 1)
                    top = FRAMES - 1;
                t.frame_index = 14'($urandom_range(0, top));
            end
            send_item(t);
        end else begin
            t.cmd = CMD_SET_LEN;
            case ($urandom_range(0, 9))
                0:       t.length = 15'(FRAMES);
                1, 2:    t.length = 15'($urandom());
                default: t.length = 15'($urandom_range(0, 48));
            endcase
            send_item(t);
        end
    endtask

    task automatic run_directed();
        send_cmd(CMD_SET_LEN, 48, 0, 16'h0, 16'h0, 3);
        send_cmd(CMD_LOAD, 48, 0, 16'h7FFF, 16'h8000, 0);
        send_cmd(CMD_LOAD, 48, 1, 16'hFFFF, 16'h0001, 0);
        send_cmd(CMD_LOAD, 48, 2, 16'h8000, 16'h7FFF, 0);
        send_cmd(CMD_NOTE_ON, 48, 0, 16'h0, 16'h0, 0);
        // zero length: voice drops out on its first tick
        send_cmd(CMD_SET_LEN, 71, 0, 16'h0, 16'h0, 0);
        send_cmd(CMD_NOTE_ON, 71, 0, 16'h0, 16'h0, 0);
        send_cmd(CMD_TICK, 0, 0, 16'h0, 16'h0, 0);
        send_cmd(CMD_TICK, 127, 16383, 16'hFFFF, 16'hFFFF, 32767);
        // retrigger while playing
        send_cmd(CMD_NOTE_ON, 48, 0, 16'h0, 16'h0, 0);
        repeat (4) send_cmd(CMD_TICK, 0, 0, 16'h0, 16'h0, 0);
        // notes outside the voice range are ignored
        send_cmd(CMD_NOTE_ON, 47, 0, 16'h0, 16'h0, 0);
        send_cmd(CMD_NOTE_ON, 72, 0, 16'h0, 16'h0, 0);
        send_cmd(CMD_LOAD, 127, 16383, 16'h7FFF, 16'h7FFF, 0);
        send_cmd(CMD_SET_LEN, 0, 0, 16'h0, 16'h0, 5);
        send_cmd(CMD_LOAD, 71, 16383, 16'h7FFF, 16'h8000, 0);
        // oversized length saturates to the full frame count
        send_cmd(CMD_SET_LEN, 70, 0, 16'h0, 16'h0, 32767);
        send_cmd(CMD_NOTE_ON, 70, 0, 16'h0, 16'h0, 0);
        send_cmd(CMD_TICK, 0, 0, 16'h0, 16'h0, 0);
        // shrink below the play position
        send_cmd(CMD_SET_LEN, 70, 0, 16'h0, 16'h0, 0);
        send_cmd(CMD_TICK, 0, 0, 16'h0, 16'h0, 0);
        send_cmd(CMD_TICK, 0, 0, 16'h0, 16'h0, 0);
    endtask

    initial begin
        logic [1:0] channel_plan [PHASES];
        int         phase;
        int         i;
        int         phase_start;
        bit         halfway;
        channel_plan = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd2, 2'd1};
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 2'd2;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_channels(2'd2);
        run_directed();

        for (phase = 0; phase < PHASES; phase++) begin
            quiesce();
            write_channels(channel_plan[phase]);
            phase_start = sent_cnt;
            halfway     = 1'b0;
            tx_burst = (phase % 3 == 1);
            rx_burst = (phase % 4 == 2);
            if (phase == 3) begin
                // stall the output long enough for ticks to back up into the input
                rx_stall = 600;
                tx_burst = 1'b1;
                for (i = 0; i < 30; i++)
                    send_cmd(CMD_TICK, $urandom_range(0, 127), 0, 16'h0, 16'h0, 0);
                tx_burst = 1'b0;
            end
            // frame fills count toward the phase budget
            while (sent_cnt - phase_start < PHASE_ITEMS) begin
                if (!halfway && sent_cnt - phase_start >= PHASE_ITEMS / 2) begin
                    quiesce();
                    halfway = 1'b1;
                end
                random_item();
            end
        end
        quiesce();

        if (sb.pending() > 0)
            $display("ERROR: %0d mixes never arrived", sb.pending());
        $display("Sent %0d transactions: %0d ticks, %0d note-ons, %0d frame loads,",
                 sent_cnt, tick_cnt, note_cnt, load_cnt);
        $display("  %0d length writes, %0d channel writes; checked %0d mixes, %0d mismatches",
                 length_cnt, cfg_cnt, sb.mixes_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/spm_pkg.sv
sv/sample_playback_mixer.sv
sim/testbench.sv
